/* hw/rtl/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp resolution cache responder
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

   localparam int ENTRIES_DEF = 16;

   // item kinds
   localparam logic [1:0] OP_RX       = 2'd0;
   localparam logic [1:0] OP_RESOLVE  = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_ANNOUNCE = 2'd3;

   // result status codes
   localparam logic [2:0] ST_TICK      = 3'd0;
   localparam logic [2:0] ST_DROPPED   = 3'd1;
   localparam logic [2:0] ST_ACCEPTED  = 3'd2;
   localparam logic [2:0] ST_HIT       = 3'd3;
   localparam logic [2:0] ST_MISS_REQ  = 3'd4;
   localparam logic [2:0] ST_LIMITED   = 3'd5;
   localparam logic [2:0] ST_ANNOUNCED = 3'd6;

   // register indexes
   localparam logic [1:0] REG_OWN_IP   = 2'd0;
   localparam logic [1:0] REG_OWN_MAC  = 2'd1;
   localparam logic [1:0] REG_LIFETIME = 2'd2;
   localparam logic [1:0] REG_INTERVAL = 2'd3;

   localparam logic [31:0] LIFETIME_RST = 32'd6000;
   localparam logic [15:0] INTERVAL_RST = 16'd20;

   // arp header checks and operations
   localparam logic [10:0] MIN_FRAME    = 11'd28;
   localparam logic [15:0] HTYPE_ETH    = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  HLEN_ETH     = 8'd6;
   localparam logic [7:0]  PLEN_IPV4    = 8'd4;
   localparam logic [15:0] OPER_REQ_RX  = 16'd1;
   localparam logic [1:0]  OPER_NONE    = 2'd0;
   localparam logic [1:0]  OPER_REQUEST = 2'd1;
   localparam logic [1:0]  OPER_REPLY   = 2'd2;
   localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;

   localparam int REQ_DATA_W = 224;
   localparam int RSP_DATA_W = 264;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_SCAN,
      S_DECIDE
   } state_type;

   // lowest field last
   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] query_ip;
      logic [31:0] tpa;
      logic [31:0] spa;
      logic [47:0] sender_mac;
      logic [15:0] arp_oper;
      logic [7:0]  proto_len;
      logic [7:0]  hw_len;
      logic [15:0] proto_type;
      logic [15:0] hw_type;
      logic [10:0] frame_len;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] tx_spa;
      logic [47:0] tx_sender_mac;
      logic [31:0] tx_tpa;
      logic [47:0] tx_target_mac;
      logic [47:0] tx_dest_mac;
      logic [1:0]  tx_oper;
      logic        tx_valid;
      logic [47:0] resolved_mac;
   } rsp_data_type;

endpackage

`default_nettype wire

/* hw/rtl/arp_cache_responder_top.sv */
// ----------------------------------------------------------------------------
// arp_cache_responder_top
// arp engine with an ipv4 to mac cache: learns senders, answers requests
// for the own address, resolves queries and sends rate limited requests
// ----------------------------------------------------------------------------
// Receive items with a good header and a nonzero sender ip, and resolve
// queries, go from S_START through S_SCAN to S_DECIDE: a sequencer walks
// the cache one entry a cycle through the registered read port of the
// entry memory, and a single 64-bit subtract and compare unit ages each
// entry. Ticks, announces and other receive items go from S_START straight
// to S_DECIDE. Only one item is in work at a time; a result waits in the
// output register and the next item is taken meanwhile. Reset clears all
// valid bits at once, so no clearing pass is needed.
`default_nettype none

module arp_cache_responder_top #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // frame_len, hw_type, proto_type, hw_len, proto_len, arp_oper,
   // sender_mac, spa, tpa, query_ip
   input  wire logic [arpc_pkg::REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // resolved_mac, tx_valid, tx_oper, tx_dest_mac, tx_target_mac,
   // tx_tpa, tx_sender_mac, tx_spa
   output logic [arpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [2:0]                         rsp_tuser,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [47:0]                   csr_data
);

   localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNTW = IDXW + 1;
   localparam logic [CNTW-1:0] CNT_END = CNTW'(ENTRIES);

   arpc_pkg::state_type state_ff, state_in;

   arpc_pkg::req_data_type item_ff, item_in;
   logic [1:0]  op_ff, op_in;

   logic [31:0] own_ip_ff, own_ip_in;
   logic [47:0] own_mac_ff, own_mac_in;
   logic [31:0] life_ff, life_in;
   logic [15:0] intv_ff, intv_in;

   logic [63:0] tick_ff, tick_in;
   logic [31:0] last_ip_ff, last_ip_in;
   logic [63:0] last_time_ff, last_time_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            rd_live_ff, rd_live_in;
   logic [IDXW-1:0] rd_idx_ff, rd_idx_in;
   logic            rd_valid_ff, rd_valid_in;

   logic            hit_ff, hit_in;
   logic [IDXW-1:0] hit_idx_ff, hit_idx_in;
   logic            hit_fresh_ff, hit_fresh_in;
   logic [47:0]     hit_mac_ff, hit_mac_in;
   logic            free_ff, free_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;

   arpc_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // entry memory
   logic [31:0] ip_mem    [ENTRIES];
   logic [47:0] mac_mem   [ENTRIES];
   logic [63:0] stamp_mem [ENTRIES];
   logic [31:0] rd_ip_ff;
   logic [47:0] rd_mac_ff;
   logic [63:0] rd_stamp_ff;
   logic        mem_we;
   logic [IDXW-1:0] mem_widx;

   logic        req_acc, csr_acc, out_free, issue, hdr_ok;
   logic [31:0] key_ip;
   logic [63:0] sub_b, age;
   logic        age_fresh, age_recent, rd_match, rd_stale;

   assign req_acc  = req_tvalid && req_tready;
   assign csr_acc  = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign issue    = (state_ff == arpc_pkg::S_SCAN) && (cnt_ff != CNT_END);

   assign hdr_ok = (item_ff.frame_len >= arpc_pkg::MIN_FRAME) &&
                   (item_ff.hw_type == arpc_pkg::HTYPE_ETH) &&
                   (item_ff.proto_type == arpc_pkg::PTYPE_IPV4) &&
                   (item_ff.hw_len == arpc_pkg::HLEN_ETH) &&
                   (item_ff.proto_len == arpc_pkg::PLEN_IPV4);

   assign key_ip = (op_ff == arpc_pkg::OP_RESOLVE) ? item_ff.query_ip : item_ff.spa;

   // shared age unit
   assign sub_b      = (state_ff == arpc_pkg::S_SCAN) ? rd_stamp_ff : last_time_ff;
   assign age        = tick_ff - sub_b;
   assign age_fresh  = (age[63:32] == 32'd0) && (age[31:0] <= life_ff);
   assign age_recent = (age[63:16] == 48'd0) && (age[15:0] < intv_ff);

   assign rd_match = rd_valid_ff && (rd_ip_ff == key_ip);
   assign rd_stale = !rd_valid_ff || !age_fresh;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arpc_pkg::S_IDLE: begin
            if (req_acc) state_in = arpc_pkg::S_START;
         end
         arpc_pkg::S_START: begin
            if ((op_ff == arpc_pkg::OP_RESOLVE) ||
                ((op_ff == arpc_pkg::OP_RX) && hdr_ok && (item_ff.spa != 32'd0)))
               state_in = arpc_pkg::S_SCAN;
            else
               state_in = arpc_pkg::S_DECIDE;
         end
         arpc_pkg::S_SCAN: begin
            if ((cnt_ff == CNT_END) && !rd_live_ff) state_in = arpc_pkg::S_DECIDE;
         end
         arpc_pkg::S_DECIDE: begin
            if (out_free) state_in = arpc_pkg::S_IDLE;
         end
         default: state_in = arpc_pkg::S_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_tready = (state_ff == arpc_pkg::S_IDLE);
      csr_ready  = 1'b1;
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      rsp_tuser  = rsp_user_ff;
   end

   // datapath
   always_comb begin
      item_in      = item_ff;
      op_in        = op_ff;
      own_ip_in    = own_ip_ff;
      own_mac_in   = own_mac_ff;
      life_in      = life_ff;
      intv_in      = intv_ff;
      tick_in      = tick_ff;
      last_ip_in   = last_ip_ff;
      last_time_in = last_time_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      rd_live_in   = issue;
      rd_idx_in    = cnt_ff[IDXW-1:0];
      rd_valid_in  = valid_ff[cnt_ff[IDXW-1:0]];
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_fresh_in = hit_fresh_ff;
      hit_mac_in   = hit_mac_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_widx     = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : '0);

      if (csr_acc) begin
         case (csr_index)
            arpc_pkg::REG_OWN_IP:   own_ip_in  = csr_data[31:0];
            arpc_pkg::REG_OWN_MAC:  own_mac_in = csr_data;
            arpc_pkg::REG_LIFETIME: life_in    = csr_data[31:0];
            arpc_pkg::REG_INTERVAL: intv_in    = csr_data[15:0];
            default: ;
         endcase
      end

      if (req_acc) begin
         item_in = arpc_pkg::req_data_type'(req_tdata);
         op_in   = req_tuser;
      end

      case (state_ff)
         arpc_pkg::S_START: begin
            cnt_in  = '0;
            hit_in  = 1'b0;
            free_in = 1'b0;
         end
         arpc_pkg::S_SCAN: begin
            if (issue) cnt_in = cnt_ff + CNTW'(1);
            if (rd_live_ff) begin
               if (rd_match && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_fresh_in = age_fresh;
                  hit_mac_in   = rd_mac_ff;
               end
               if (rd_stale && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
            end
         end
         arpc_pkg::S_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (op_ff)
                  arpc_pkg::OP_RX: begin
                     if (!hdr_ok) begin
                        rsp_user_in = arpc_pkg::ST_DROPPED;
                     end else begin
                        rsp_user_in = arpc_pkg::ST_ACCEPTED;
                        if (item_ff.spa != 32'd0) begin
                           mem_we             = 1'b1;
                           valid_in[mem_widx] = 1'b1;
                        end
                        if ((item_ff.arp_oper == arpc_pkg::OPER_REQ_RX) &&
                            (item_ff.tpa == own_ip_ff)) begin
                           rsp_data_in.tx_valid      = 1'b1;
                           rsp_data_in.tx_oper       = arpc_pkg::OPER_REPLY;
                           rsp_data_in.tx_dest_mac   = item_ff.sender_mac;
                           rsp_data_in.tx_target_mac = item_ff.sender_mac;
                           rsp_data_in.tx_tpa        = item_ff.spa;
                           rsp_data_in.tx_sender_mac = own_mac_ff;
                           rsp_data_in.tx_spa        = own_ip_ff;
                        end
                     end
                  end
                  arpc_pkg::OP_RESOLVE: begin
                     if (hit_ff && hit_fresh_ff) begin
                        rsp_user_in              = arpc_pkg::ST_HIT;
                        rsp_data_in.resolved_mac = hit_mac_ff;
                     end else begin
                        if (hit_ff) valid_in[hit_idx_ff] = 1'b0;
                        if ((last_ip_ff == item_ff.query_ip) && age_recent) begin
                           rsp_user_in = arpc_pkg::ST_LIMITED;
                        end else begin
                           rsp_user_in               = arpc_pkg::ST_MISS_REQ;
                           last_ip_in                = item_ff.query_ip;
                           last_time_in              = tick_ff;
                           rsp_data_in.tx_valid      = 1'b1;
                           rsp_data_in.tx_oper       = arpc_pkg::OPER_REQUEST;
                           rsp_data_in.tx_dest_mac   = arpc_pkg::BCAST_MAC;
                           rsp_data_in.tx_tpa        = item_ff.query_ip;
                           rsp_data_in.tx_sender_mac = own_mac_ff;
                           rsp_data_in.tx_spa        = own_ip_ff;
                        end
                     end
                  end
                  arpc_pkg::OP_TICK: begin
                     rsp_user_in = arpc_pkg::ST_TICK;
                     tick_in     = tick_ff + 64'd1;
                  end
                  default: begin
                     rsp_user_in               = arpc_pkg::ST_ANNOUNCED;
                     rsp_data_in.tx_valid      = 1'b1;
                     rsp_data_in.tx_oper       = arpc_pkg::OPER_REQUEST;
                     rsp_data_in.tx_dest_mac   = arpc_pkg::BCAST_MAC;
                     rsp_data_in.tx_tpa        = own_ip_ff;
                     rsp_data_in.tx_sender_mac = own_mac_ff;
                     rsp_data_in.tx_spa        = own_ip_ff;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ip_mem[mem_widx]    <= item_ff.spa;
         mac_mem[mem_widx]   <= item_ff.sender_mac;
         stamp_mem[mem_widx] <= tick_ff;
      end
      rd_ip_ff    <= ip_mem[cnt_ff[IDXW-1:0]];
      rd_mac_ff   <= mac_mem[cnt_ff[IDXW-1:0]];
      rd_stamp_ff <= stamp_mem[cnt_ff[IDXW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arpc_pkg::S_IDLE;
         own_ip_ff    <= '0;
         own_mac_ff   <= '0;
         life_ff      <= arpc_pkg::LIFETIME_RST;
         intv_ff      <= arpc_pkg::INTERVAL_RST;
         tick_ff      <= '0;
         last_ip_ff   <= '0;
         last_time_ff <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rd_live_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_ip_ff    <= own_ip_in;
         own_mac_ff   <= own_mac_in;
         life_ff      <= life_in;
         intv_ff      <= intv_in;
         tick_ff      <= tick_in;
         last_ip_ff   <= last_ip_in;
         last_time_ff <= last_time_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rd_live_ff   <= rd_live_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      op_ff        <= op_in;
      rd_idx_ff    <= rd_idx_in;
      rd_valid_ff  <= rd_valid_in;
      hit_idx_ff   <= hit_idx_in;
      hit_fresh_ff <= hit_fresh_in;
      hit_mac_ff   <= hit_mac_in;
      free_idx_ff  <= free_idx_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // the scan has covered every entry before a decision
   a_scan_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arpc_pkg::S_DECIDE && $past(state_ff) == arpc_pkg::S_SCAN)
      |-> (cnt_ff == CNT_END))
      else $error("decision taken before the cache scan finished");

   // a transmitted word belongs to a kind that sends
   a_tx_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.tx_valid)
      |-> (rsp_user_ff == arpc_pkg::ST_ACCEPTED || rsp_user_ff == arpc_pkg::ST_MISS_REQ ||
           rsp_user_ff == arpc_pkg::ST_ANNOUNCED))
      else $error("tx flagged on a word that never transmits");

   // a hit carries no transmit
   a_hit_no_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == arpc_pkg::ST_HIT) |-> !rsp_data_ff.tx_valid)
      else $error("hit word carries a transmit");

   // time moves only on a tick item
   a_tick_only: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && tick_ff != $past(tick_ff))
      |-> ($past(state_ff) == arpc_pkg::S_DECIDE && $past(op_ff) == arpc_pkg::OP_TICK))
      else $error("tick counter moved outside a tick item");

endmodule

`default_nettype wire
